// ===== rtl/u16u8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// shared types, constants and byte-forming function for the utf-16 to utf-8 transcoder
// no dependencies

package u16u8_pkg;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int CP_W = 21;

	// surrogate ranges by their top six bits
	localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
	localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

	localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;
	localparam logic [CP_W-1:0] MAX_1BYTE = 21'h00_007F;
	localparam logic [CP_W-1:0] MAX_2BYTE = 21'h00_07FF;
	localparam logic [CP_W-1:0] MAX_3BYTE = 21'h00_FFFF;

	localparam logic [7:0] LEAD_2BYTE = 8'b1100_0000;
	localparam logic [7:0] LEAD_3BYTE = 8'b1110_0000;
	localparam logic [7:0] LEAD_4BYTE = 8'b1111_0000;
	localparam logic [7:0] CONT_BYTE  = 8'b1000_0000;

	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_IGNORE_INVALID = 1'b0;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_HIGH_NO_LOW = 2'd1,
		ST_LONE_LOW    = 2'd2,
		ST_HIGH_AT_END = 2'd3
	} status_t;

	// one queued job: a code point to encode or a single error word
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [1:0]      last_idx;
		status_t         status;
	} job_t;

	function automatic logic [1:0] cp_last_idx(input logic [CP_W-1:0] cp);
		logic [1:0] r;
		if (cp <= MAX_1BYTE)      r = 2'd0;
		else if (cp <= MAX_2BYTE) r = 2'd1;
		else if (cp <= MAX_3BYTE) r = 2'd2;
		else                      r = 2'd3;
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input job_t job, input logic [1:0] idx);
		logic [7:0] r;
		logic [7:0] c0, c1, c2;
		c0 = CONT_BYTE | {2'b00, job.cp[5:0]};
		c1 = CONT_BYTE | {2'b00, job.cp[11:6]};
		c2 = CONT_BYTE | {2'b00, job.cp[17:12]};
		r = 8'h00;
		if (job.status == ST_OK) begin
			unique case (job.last_idx)
				2'd0: r = {1'b0, job.cp[6:0]};
				2'd1: r = (idx == 2'd0) ? (LEAD_2BYTE | {3'b000, job.cp[10:6]}) : c0;
				2'd2: begin
					unique case (idx)
						2'd0:    r = LEAD_3BYTE | {4'b0000, job.cp[15:12]};
						2'd1:    r = c1;
						default: r = c0;
					endcase
				end
				default: begin
					unique case (idx)
						2'd0: r = LEAD_4BYTE | {5'b00000, job.cp[20:18]};
						2'd1: r = c2;
						2'd2: r = c1;
						default: r = c0;
					endcase
				end
			endcase
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/u16u8_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// valid/ready channel interfaces: utf-16 code units in, utf-8 bytes out
// no dependencies

interface u16u8_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        end_of_string;

	modport source(output valid, code_unit, end_of_string, input ready);
	modport sink(input valid, code_unit, end_of_string, output ready);
endinterface

interface u16u8_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last_in_run;

	modport source(output valid, out_byte, status, last_in_run, input ready);
	modport sink(input valid, out_byte, status, last_in_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/u16u8_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// short job queue between the classifier and the byte serializer
// depends on u16u8_pkg

module u16u8_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u16u8_pkg::job_t push_job,
	output logic                 full,
	input  wire logic            pop,
	output logic                 empty,
	output u16u8_pkg::job_t      head
);

	u16u8_pkg::job_t                     mem_q [u16u8_pkg::FIFO_DEPTH];
	logic [u16u8_pkg::FIFO_PTR_W-1:0]    wr_ptr_q;
	logic [u16u8_pkg::FIFO_PTR_W-1:0]    rd_ptr_q;
	logic [u16u8_pkg::FIFO_CNT_W-1:0]    count_q;

	localparam logic [u16u8_pkg::FIFO_PTR_W-1:0] LAST_PTR =
		u16u8_pkg::FIFO_PTR_W'(u16u8_pkg::FIFO_DEPTH - 1);
	localparam logic [u16u8_pkg::FIFO_CNT_W-1:0] DEPTH_CNT =
		u16u8_pkg::FIFO_CNT_W'(u16u8_pkg::FIFO_DEPTH);

	assign full  = (count_q == DEPTH_CNT);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("job queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("job queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/u16u8_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// front end: accepts code units, pairs surrogates, tracks errors, queues jobs
// depends on u16u8_pkg, u16u8_if

module u16u8_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         ignore_invalid,
	u16u8_unit_if.sink        units,
	input  wire logic         queue_full,
	output logic              push,
	output u16u8_pkg::job_t   push_job
);

	logic       high_pending_q;
	logic [9:0] saved_high_q;
	logic       aborted_q;

	logic       high_pending_d;
	logic [9:0] saved_high_d;
	logic       aborted_d;
	logic       has_job;
	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       handled;
	logic [u16u8_pkg::CP_W-1:0] cp;

	assign units.ready = !queue_full;
	assign accept      = units.valid && units.ready;
	assign is_high     = (units.code_unit[15:10] == u16u8_pkg::HIGH_SURR_TAG);
	assign is_low      = (units.code_unit[15:10] == u16u8_pkg::LOW_SURR_TAG);

	always_comb begin
		high_pending_d  = high_pending_q;
		saved_high_d    = saved_high_q;
		aborted_d       = aborted_q;
		has_job         = 1'b0;
		handled         = 1'b0;
		cp              = {5'b0, units.code_unit};
		push_job.status = u16u8_pkg::ST_OK;
		if (!aborted_q) begin
			if (high_pending_q) begin
				high_pending_d = 1'b0;
				saved_high_d   = '0;
				if (is_low) begin
					// supplementary plane: base plus the twenty payload bits
					cp      = u16u8_pkg::SUPP_BASE + {1'b0, saved_high_q, units.code_unit[9:0]};
					has_job = 1'b1;
					handled = 1'b1;
				end else if (!ignore_invalid) begin
					has_job         = 1'b1;
					push_job.status = u16u8_pkg::ST_HIGH_NO_LOW;
					aborted_d       = 1'b1;
					handled         = 1'b1;
				end
			end
			if (!handled) begin
				if (is_high) begin
					if (units.end_of_string) begin
						if (!ignore_invalid) begin
							has_job         = 1'b1;
							push_job.status = u16u8_pkg::ST_HIGH_AT_END;
							aborted_d       = 1'b1;
						end
					end else begin
						high_pending_d = 1'b1;
						saved_high_d   = units.code_unit[9:0];
					end
				end else if (is_low) begin
					if (!ignore_invalid) begin
						has_job         = 1'b1;
						push_job.status = u16u8_pkg::ST_LONE_LOW;
						aborted_d       = 1'b1;
					end
				end else begin
					has_job = 1'b1;
				end
			end
		end
		if (units.end_of_string) begin
			high_pending_d = 1'b0;
			saved_high_d   = '0;
			aborted_d      = 1'b0;
		end
		push_job.cp       = cp;
		push_job.last_idx = (push_job.status == u16u8_pkg::ST_OK) ?
			u16u8_pkg::cp_last_idx(cp) : 2'd0;
	end

	assign push = accept && has_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q <= 1'b0;
			saved_high_q   <= '0;
			aborted_q      <= 1'b0;
		end else if (accept) begin
			high_pending_q <= high_pending_d;
			saved_high_q   <= saved_high_d;
			aborted_q      <= aborted_d;
		end
	end

	a_abort_clears_high: assert property (@(posedge clk) disable iff (!arst_n)
		aborted_q |-> !high_pending_q)
		else $error("aborted string still holds a high surrogate");

endmodule

`default_nettype wire

// ===== rtl/u16u8_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// back end: serializes each queued job into utf-8 words through an output register
// depends on u16u8_pkg, u16u8_if

module u16u8_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            queue_empty,
	input  wire u16u8_pkg::job_t head,
	output logic                 pop,
	u16u8_byte_if.source         utf8
);

	u16u8_pkg::job_t job_q;
	logic [1:0]      idx_q;
	logic            busy_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic [1:0]      status_q;
	logic            last_q;

	logic advance;
	logic job_done;

	assign advance  = busy_q && (!out_valid_q || utf8.ready);
	assign job_done = advance && (idx_q == job_q.last_idx);
	assign pop      = !queue_empty && (!busy_q || job_done);

	assign utf8.valid       = out_valid_q;
	assign utf8.out_byte    = out_byte_q;
	assign utf8.status      = status_q;
	assign utf8.last_in_run = last_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (advance) begin
			out_byte_q <= u16u8_pkg::utf8_byte(job_q, idx_q);
			status_q   <= job_q.status;
			last_q     <= (idx_q == job_q.last_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (job_done) begin
				busy_q <= 1'b0;
			end else if (advance) begin
				idx_q <= idx_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (utf8.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= job_q.last_idx)
		else $error("byte index beyond encoded length");

	a_error_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != u16u8_pkg::ST_OK |-> out_byte_q == 8'h00 && last_q)
		else $error("error word carries data or is not last");

endmodule

`default_nettype wire

// ===== rtl/utf16_to_utf8_transcoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// top level of the utf-16 to utf-8 transcoder: apb register, front end, job queue, back end
// depends on u16u8_pkg, u16u8_if, u16u8_front, u16u8_fifo, u16u8_back

// The block takes one UTF-16 code unit per word on the units channel, with an
// end-of-string flag, and gives UTF-8 bytes one word at a time on the utf8
// channel, the final word caused by each unit flagged with last_in_run. A high
// surrogate is held (no output) until its low partner arrives, then the pair
// leaves as four bytes. Invalid sequences follow the ignore_invalid register
// (apb offset 0x0, bit 0): set, the bad unit is dropped quietly; clear, one
// word with a zero byte and a nonzero status is sent and the rest of the
// string is swallowed until its end-of-string unit. The front end takes a unit
// in every cycle while the two-entry job queue has room; the back end sends one
// word per cycle while the receiver is ready, so a unit gives 0 to 4 words at the
// output (1 for ascii or an error word, 2 or 3 for wider bmp characters, 4 for
// the low half of a surrogate pair) and that serializer sets the sustained rate.
// Units that give no output (a held high surrogate, a dropped or swallowed unit)
// are handled by the front only. Change ignore_invalid only while the block is idle.

module utf16_to_utf8_transcoder_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [u16u8_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	u16u8_unit_if.sink                         units,
	u16u8_byte_if.source                       utf8
);

	// configuration register
	logic ignore_invalid_q;
	logic reg_hit;
	logic reg_write;

	// queue handshakes
	logic            push;
	logic            pop;
	logic            queue_full;
	logic            queue_empty;
	u16u8_pkg::job_t push_job;
	u16u8_pkg::job_t head;

	assign pready    = 1'b1;
	assign reg_hit   = (paddr[u16u8_pkg::ADDR_W-1] == u16u8_pkg::REG_IGNORE_INVALID);
	assign reg_write = psel && penable && pwrite && pready && reg_hit;
	assign prdata    = reg_hit ? {31'b0, ignore_invalid_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_invalid_q <= 1'b0;
		end else if (reg_write) begin
			ignore_invalid_q <= pwdata[0];
		end
	end

	// front end: classification and surrogate pairing
	u16u8_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.ignore_invalid (ignore_invalid_q),
		.units          (units),
		.queue_full     (queue_full),
		.push           (push),
		.push_job       (push_job)
	);

	// decoupling queue, lets the front run ahead of a stalled output
	u16u8_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head     (head)
	);

	// back end: one utf-8 word per cycle through the output register while the receiver is ready
	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head        (head),
		.pop         (pop),
		.utf8        (utf8)
	);

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for utf16_to_utf8_transcoder_core: utf-16 code units in, utf-8 words out
// depends on u16u8_pkg and u16u8_if from the rtl, and on the transcoder core itself

module tb_top;

	// overall run limit, far above the slowest legal run (4 words per unit, stalls everywhere)
	localparam int CYCLE_LIMIT = 200_000;
	// the core has a front end, a two-entry job queue and a serializer; let it settle
	localparam int SETTLE_CYCLES = 10;
	// receiver hold-off long enough to fill the job queue and stall the unit channel
	localparam int LONG_HOLD_CYCLES = 60;
	localparam logic [u16u8_pkg::ADDR_W-1:0] IGNORE_INVALID_ADDR =
		u16u8_pkg::ADDR_W'({u16u8_pkg::REG_IGNORE_INVALID, 2'b00});

	// one expected word on the utf8 channel
	typedef struct packed {
		logic [7:0]         out_byte;
		u16u8_pkg::status_t status;
		logic               last_in_run;
	} utf8_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [u16u8_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	u16u8_unit_if units_if ();
	u16u8_byte_if utf8_if ();

	utf16_to_utf8_transcoder_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.units   (units_if),
		.utf8    (utf8_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor state: our own copy of the register and the string state
	// ------------------------------------------------------------------
	logic       lenient_mode;     // ignore_invalid as last written
	logic       surr_waiting;     // a high surrogate is held
	logic [9:0] surr_high_bits;   // its payload bits
	logic       string_dead;      // strict error seen, swallow until end of string

	utf8_word_t expected_utf8[$]; // words still owed by the core, oldest first
	utf8_word_t run_words[$];     // words caused by the unit being predicted

	// shared knobs and counters
	logic gaps_on;
	int   hold_left;
	int   stall_left;
	int   cycle_count;
	int   fail_count;
	int   units_seen;
	int   strings_seen;
	int   words_checked;
	int   error_words;

	task automatic report_mismatch(input string what, input int want, input int got);
		fail_count++;
		$display("mismatch @%0d: %s expected 0x%0h got 0x%0h", cycle_count, what, want, got);
	endtask

	function automatic void push_word(input logic [7:0] b, input u16u8_pkg::status_t st);
		run_words.insert(run_words.size(), '{out_byte: b, status: st, last_in_run: 1'b0});
	endfunction

	// strict-mode error: a single zero word with the cause, then the string is dead
	function automatic void push_error(input u16u8_pkg::status_t st);
		push_word(8'h00, st);
		string_dead = 1'b1;
	endfunction

	// utf-8 encoding of one code point, 1 to 4 words
	function automatic void add_utf8_bytes(input logic [u16u8_pkg::CP_W-1:0] cp);
		if (cp <= u16u8_pkg::MAX_1BYTE) begin
			push_word({1'b0, cp[6:0]}, u16u8_pkg::ST_OK);
		end else if (cp <= u16u8_pkg::MAX_2BYTE) begin
			push_word(u16u8_pkg::LEAD_2BYTE | {3'b000, cp[10:6]}, u16u8_pkg::ST_OK);
			push_word(u16u8_pkg::CONT_BYTE | {2'b00, cp[5:0]}, u16u8_pkg::ST_OK);
		end else if (cp <= u16u8_pkg::MAX_3BYTE) begin
			push_word(u16u8_pkg::LEAD_3BYTE | {4'b0000, cp[15:12]}, u16u8_pkg::ST_OK);
			push_word(u16u8_pkg::CONT_BYTE | {2'b00, cp[11:6]}, u16u8_pkg::ST_OK);
			push_word(u16u8_pkg::CONT_BYTE | {2'b00, cp[5:0]}, u16u8_pkg::ST_OK);
		end else begin
			push_word(u16u8_pkg::LEAD_4BYTE | {5'b00000, cp[20:18]}, u16u8_pkg::ST_OK);
			push_word(u16u8_pkg::CONT_BYTE | {2'b00, cp[17:12]}, u16u8_pkg::ST_OK);
			push_word(u16u8_pkg::CONT_BYTE | {2'b00, cp[11:6]}, u16u8_pkg::ST_OK);
			push_word(u16u8_pkg::CONT_BYTE | {2'b00, cp[5:0]}, u16u8_pkg::ST_OK);
		end
	endfunction

	// works out the words that one accepted code unit must cause
	function automatic void transcode_unit(input logic [15:0] cu, input logic eos);
		logic is_high;
		logic is_low;
		logic done;
		is_high = (cu[15:10] == u16u8_pkg::HIGH_SURR_TAG);
		is_low  = (cu[15:10] == u16u8_pkg::LOW_SURR_TAG);
		done    = 1'b0;
		run_words.delete();
		if (!string_dead) begin
			if (surr_waiting) begin
				surr_waiting = 1'b0;
				if (is_low) begin
					add_utf8_bytes(u16u8_pkg::SUPP_BASE +
						u16u8_pkg::CP_W'({surr_high_bits, cu[9:0]}));
					done = 1'b1;
				end else if (!lenient_mode) begin
					push_error(u16u8_pkg::ST_HIGH_NO_LOW);
					done = 1'b1;
				end
				surr_high_bits = '0;
				// lenient: the held high is simply forgotten and this unit goes on below
			end
			if (!done) begin
				if (is_high) begin
					if (eos) begin
						if (!lenient_mode)
							push_error(u16u8_pkg::ST_HIGH_AT_END);
					end else begin
						surr_waiting   = 1'b1;
						surr_high_bits = cu[9:0];
					end
				end else if (is_low) begin
					if (!lenient_mode)
						push_error(u16u8_pkg::ST_LONE_LOW);
				end else begin
					add_utf8_bytes(u16u8_pkg::CP_W'(cu));
				end
			end
		end
		if (run_words.size() > 0)
			run_words[$].last_in_run = 1'b1;
		foreach (run_words[i])
			expected_utf8.insert(expected_utf8.size(), run_words[i]);
		// end of string wipes everything, aborted or not
		if (eos) begin
			surr_waiting   = 1'b0;
			surr_high_bits = '0;
			string_dead    = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------
	// monitors
	// ------------------------------------------------------------------

	// every unit the core accepts goes through the predictor
	always @(posedge clk) begin
		if (arst_n && units_if.valid && units_if.ready) begin
			units_seen++;
			if (units_if.end_of_string)
				strings_seen++;
			transcode_unit(units_if.code_unit, units_if.end_of_string);
		end
	end

	// every word the core sends is matched against the oldest expectation
	always @(posedge clk) begin
		utf8_word_t want;
		if (arst_n && utf8_if.valid && utf8_if.ready) begin
			words_checked++;
			if (utf8_if.status != u16u8_pkg::ST_OK)
				error_words++;
			if (expected_utf8.size() == 0) begin
				report_mismatch("unexpected word, out_byte", 0, utf8_if.out_byte);
			end else begin
				want = expected_utf8.pop_front();
				if (utf8_if.out_byte != want.out_byte)
					report_mismatch("out_byte", want.out_byte, utf8_if.out_byte);
				if (utf8_if.status != want.status)
					report_mismatch("status", want.status, utf8_if.status);
				if (utf8_if.last_in_run != want.last_in_run)
					report_mismatch("last_in_run", want.last_in_run, utf8_if.last_in_run);
			end
		end
	end

	// receiver: short random stalls, or one long hold-off when a test asks for it
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			utf8_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left = stall_left - 1;
			utf8_if.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			utf8_if.ready <= 1'b0;
		end else begin
			utf8_if.ready <= 1'b1;
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still owed", cycle_count,
				expected_utf8.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// offers one unit, maybe after a short idle burst, and returns at the accepting edge;
	// valid stays high so the next call can follow back to back
	task automatic send_unit(input logic [15:0] cu, input logic eos);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			units_if.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		units_if.valid         <= 1'b1;
		units_if.code_unit     <= cu;
		units_if.end_of_string <= eos;
		do @(posedge clk); while (!units_if.ready);
	endtask

	// stops offering and waits until the core owes nothing and has gone quiet
	task automatic wait_idle();
		units_if.valid <= 1'b0;
		do @(posedge clk); while (expected_utf8.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// apb write of ignore_invalid: setup, access, written at the edge with pready high
	task automatic write_ignore_invalid(input logic lenient);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= IGNORE_INVALID_ADDR;
		// upper bits are don't-care for a one-bit register
		pwdata  <= {31'($urandom), lenient};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		lenient_mode = lenient;
	endtask

	// one random string: mostly well-formed text of every width, some noise and
	// broken surrogates; a lone high may land on the end-of-string unit
	task automatic send_random_string(input int max_len, output int sent);
		logic [15:0] text[$];
		int len;
		len = $urandom_range(1, max_len);
		while (text.size() < len) begin
			case ($urandom_range(0, 9))
				0, 1, 2: text.insert(text.size(), 16'($urandom_range(0, 16'h007F)));
				3:       text.insert(text.size(), 16'($urandom_range(16'h0080, 16'h07FF)));
				4:       text.insert(text.size(), 16'($urandom_range(16'h0800, 16'hD7FF)));
				5:       text.insert(text.size(), 16'($urandom_range(16'hE000, 16'hFFFF)));
				6, 7: begin
					text.insert(text.size(), 16'($urandom_range(16'hD800, 16'hDBFF)));
					text.insert(text.size(), 16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				8:       text.insert(text.size(), 16'($urandom));
				default: text.insert(text.size(), 16'($urandom_range(16'hD800, 16'hDFFF)));
			endcase
		end
		foreach (text[k])
			send_unit(text[k], k == text.size() - 1);
		sent = text.size();
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	// width boundaries of 1, 2, 3 and 4 byte encodings, strict mode
	task automatic test_encoding_limits();
		write_ignore_invalid(1'b0);
		send_unit(16'h0000, 1'b0);
		send_unit(16'h007F, 1'b0);
		send_unit(16'h0080, 1'b0);
		send_unit(16'h07FF, 1'b0);
		send_unit(16'h0800, 1'b0);
		send_unit(16'hFFFF, 1'b1);
		// smallest and largest supplementary code points
		send_unit(16'hD800, 1'b0);
		send_unit(16'hDC00, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDFFF, 1'b1);
		wait_idle();
	endtask

	// every strict-mode error, and the swallowing that follows one
	task automatic test_strict_errors();
		// high then non-low: one error word, rest of the string swallowed
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'h0042, 1'b1);
		// lone low, then the end unit is swallowed
		send_unit(16'hDC00, 1'b0);
		send_unit(16'h0041, 1'b1);
		// high surrogate as the end unit
		send_unit(16'hD8FF, 1'b1);
		wait_idle();
	endtask

	// lenient mode drops bad units quietly and keeps the one after a dropped high
	task automatic test_lenient_drops();
		write_ignore_invalid(1'b1);
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		send_unit(16'hDC00, 1'b0);
		// high then high: the first is dropped, the second pairs with the low
		send_unit(16'hD900, 1'b0);
		send_unit(16'hDBFF, 1'b0);
		send_unit(16'hDC05, 1'b0);
		send_unit(16'hD800, 1'b1);
		wait_idle();
	endtask

	// register changed while a string is open: aborted stays aborted, a held high
	// meets the new mode
	task automatic test_mode_switch_midstring();
		write_ignore_invalid(1'b0);
		send_unit(16'hD800, 1'b0);
		send_unit(16'h0041, 1'b0);
		wait_idle();
		write_ignore_invalid(1'b1);
		send_unit(16'h0042, 1'b1);
		send_unit(16'hDA00, 1'b0);
		wait_idle();
		write_ignore_invalid(1'b0);
		send_unit(16'h0043, 1'b1);
		wait_idle();
	endtask

	// receiver holds off long enough that the job queue fills and the unit channel stalls
	task automatic test_output_backpressure();
		int n;
		int sent;
		sent = 0;
		@(negedge clk);
		hold_left = LONG_HOLD_CYCLES;
		@(posedge clk);
		while (sent < 20) begin
			send_random_string(6, n);
			sent += n;
		end
		wait_idle();
	endtask

	// a random phase under one register setting and one idling style
	task automatic test_random_text(input logic lenient, input logic idle, input int budget);
		int n;
		int sent;
		sent = 0;
		gaps_on = idle;
		write_ignore_invalid(lenient);
		while (sent < budget) begin
			send_random_string(8, n);
			sent += n;
		end
		wait_idle();
	endtask

	initial begin
		arst_n                 = 1'b0;
		psel                   = 1'b0;
		penable                = 1'b0;
		pwrite                 = 1'b0;
		paddr                  = '0;
		pwdata                 = '0;
		units_if.valid         = 1'b0;
		units_if.code_unit     = '0;
		units_if.end_of_string = 1'b0;
		utf8_if.ready          = 1'b0;
		lenient_mode           = 1'b0;
		surr_waiting           = 1'b0;
		surr_high_bits         = '0;
		string_dead            = 1'b0;
		gaps_on                = 1'b1;
		hold_left              = 0;
		stall_left             = 0;
		cycle_count            = 0;
		fail_count             = 0;
		units_seen             = 0;
		strings_seen           = 0;
		words_checked          = 0;
		error_words            = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encoding_limits();
		test_strict_errors();
		test_lenient_drops();
		test_mode_switch_midstring();
		test_output_backpressure();
		test_random_text(1'b0, 1'b1, 35);
		test_random_text(1'b1, 1'b1, 35);
		// last part runs flat out on both sides
		test_random_text(1'b0, 1'b0, 25);
		test_random_text(1'b1, 1'b0, 25);

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("sent %0d code units in %0d strings through strict and lenient settings,",
			units_seen, strings_seen);
		$display("with idle gaps, stalls and a long receiver hold; %0d words checked, %0d errors",
			words_checked, error_words);
		if (fail_count == 0 && expected_utf8.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
